[rtl/scancode_to_ascii_decoder_core_assert.svh]
// ----------------------------------------------------------------------------
// Scan code decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_DECODER_CORE_ASSERT_SVH
`define SCANCODE_TO_ASCII_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define SC2A_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SC2A_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/sc2a_pkg.sv]
// ----------------------------------------------------------------------------
// Scan code decoder package
// Key codes, modifier bit positions, decode types and the set-1 US tables.
// ----------------------------------------------------------------------------
package sc2a_pkg;

  localparam int CodeW  = 8;
  localparam int KeyW   = 7;
  localparam int CharW  = 7;
  localparam int ModW   = 6;

  localparam logic [KeyW-1:0] KeyCtrl    = 7'h1D;
  localparam logic [KeyW-1:0] KeyLShift  = 7'h2A;
  localparam logic [KeyW-1:0] KeyRShift  = 7'h36;
  localparam logic [KeyW-1:0] KeyAlt     = 7'h38;
  localparam logic [KeyW-1:0] KeyCaps    = 7'h3A;
  localparam logic [KeyW-1:0] KeyNum     = 7'h45;
  localparam logic [KeyW-1:0] KeyScroll  = 7'h46;

  localparam int ModAlt    = 0;
  localparam int ModCtrl   = 1;
  localparam int ModShift  = 2;
  localparam int ModCaps   = 3;
  localparam int ModNum    = 4;
  localparam int ModScroll = 5;

  localparam int BreakBit  = 7;

  typedef struct packed {
    logic              emit;
    logic [CharW-1:0]  ch;
    logic [ModW-1:0]   mod_nxt;
  } dec_res_t;

  function automatic logic [CharW-1:0] plain_char(input logic [KeyW-1:0] key);
    logic [CharW-1:0] c;
    case (key)
      7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;  7'h05: c = 7'h34;
      7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;  7'h09: c = 7'h38;
      7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;  7'h0D: c = 7'h3D;
      7'h0E: c = 7'h08;  7'h0F: c = 7'h09;
      7'h10: c = 7'h71;  7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;
      7'h14: c = 7'h74;  7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;
      7'h18: c = 7'h6F;  7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;
      7'h1C: c = 7'h0A;
      7'h1E: c = 7'h61;  7'h1F: c = 7'h73;  7'h20: c = 7'h64;  7'h21: c = 7'h66;
      7'h22: c = 7'h67;  7'h23: c = 7'h68;  7'h24: c = 7'h6A;  7'h25: c = 7'h6B;
      7'h26: c = 7'h6C;  7'h27: c = 7'h3B;  7'h28: c = 7'h27;  7'h29: c = 7'h60;
      7'h2B: c = 7'h5C;
      7'h2C: c = 7'h7A;  7'h2D: c = 7'h78;  7'h2E: c = 7'h63;  7'h2F: c = 7'h76;
      7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;  7'h33: c = 7'h2C;
      7'h34: c = 7'h2E;  7'h35: c = 7'h2F;
      7'h37: c = 7'h2A;  7'h39: c = 7'h20;
      7'h47: c = 7'h37;  7'h48: c = 7'h38;  7'h49: c = 7'h39;  7'h4A: c = 7'h2D;
      7'h4B: c = 7'h34;  7'h4C: c = 7'h35;  7'h4D: c = 7'h36;  7'h4E: c = 7'h2B;
      7'h4F: c = 7'h31;  7'h50: c = 7'h32;  7'h51: c = 7'h33;  7'h52: c = 7'h30;
      7'h53: c = 7'h2E;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [CharW-1:0] shift_char(input logic [KeyW-1:0] key);
    logic [CharW-1:0] c;
    case (key)
      7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;  7'h05: c = 7'h24;
      7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;  7'h09: c = 7'h2A;
      7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;  7'h0D: c = 7'h2B;
      7'h10: c = 7'h51;  7'h11: c = 7'h57;  7'h12: c = 7'h45;  7'h13: c = 7'h52;
      7'h14: c = 7'h54;  7'h15: c = 7'h59;  7'h16: c = 7'h55;  7'h17: c = 7'h49;
      7'h18: c = 7'h4F;  7'h19: c = 7'h50;  7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;
      7'h1E: c = 7'h41;  7'h1F: c = 7'h53;  7'h20: c = 7'h44;  7'h21: c = 7'h46;
      7'h22: c = 7'h47;  7'h23: c = 7'h48;  7'h24: c = 7'h4A;  7'h25: c = 7'h4B;
      7'h26: c = 7'h4C;  7'h27: c = 7'h3A;  7'h28: c = 7'h22;  7'h29: c = 7'h7E;
      7'h2B: c = 7'h7C;
      7'h2C: c = 7'h5A;  7'h2D: c = 7'h58;  7'h2E: c = 7'h43;  7'h2F: c = 7'h56;
      7'h30: c = 7'h42;  7'h31: c = 7'h4E;  7'h32: c = 7'h4D;  7'h33: c = 7'h3C;
      7'h34: c = 7'h3E;  7'h35: c = 7'h3F;
      default: c = plain_char(key);
    endcase
    return c;
  endfunction

endpackage

[rtl/sc2a_decode.sv]
// ----------------------------------------------------------------------------
// Scan code decode
// Modifier update and table lookup for one registered scan code.
// ----------------------------------------------------------------------------
module sc2a_decode
  import sc2a_pkg::*;
(
  input  logic [CodeW-1:0] code,
  input  logic [ModW-1:0]  mod_cur,
  output dec_res_t         res
);

  logic [KeyW-1:0]  key;
  logic             brk;
  logic [ModW-1:0]  mod_nxt;
  logic [CharW-1:0] pch;

  assign key = code[KeyW-1:0];
  assign brk = code[BreakBit];
  assign pch = plain_char(key);

  always_comb begin
    mod_nxt = mod_cur;
    if (brk) begin
      case (key)
        KeyCtrl:   mod_nxt[ModCtrl]  = 1'b0;
        KeyLShift: mod_nxt[ModShift] = 1'b0;
        KeyRShift: mod_nxt[ModShift] = 1'b0;
        KeyAlt:    mod_nxt[ModAlt]   = 1'b0;
        default:   mod_nxt = mod_cur;
      endcase
    end else begin
      case (key)
        KeyCtrl:   mod_nxt[ModCtrl]   = 1'b1;
        KeyLShift: mod_nxt[ModShift]  = 1'b1;
        KeyRShift: mod_nxt[ModShift]  = 1'b1;
        KeyAlt:    mod_nxt[ModAlt]    = 1'b1;
        KeyCaps:   mod_nxt[ModCaps]   = ~mod_cur[ModCaps];
        KeyNum:    mod_nxt[ModNum]    = ~mod_cur[ModNum];
        KeyScroll: mod_nxt[ModScroll] = ~mod_cur[ModScroll];
        default:   mod_nxt = mod_cur;
      endcase
    end
  end

  always_comb begin
    res.mod_nxt = mod_nxt;
    res.emit    = !brk && (pch != '0);
    res.ch      = (mod_nxt[ModShift] || mod_nxt[ModCaps]) ? shift_char(key) : pch;
  end

endmodule

[rtl/scancode_to_ascii_decoder_core.sv]
// Throughput: one scan code per cycle, limited only by the output register.
// Each request sits in the input register, decodes, and loads the result register if it yields a character.
// Reset (rst_n low, synchronous) clears the tracked modifier flags and both valid bits, not the output registers.
// ----------------------------------------------------------------------------
// Scan code to ASCII decoder core
// Set-1 US layout decoder with modifier tracking, valid/ready on both sides.
// ----------------------------------------------------------------------------
module scancode_to_ascii_decoder_core
  import sc2a_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CodeW-1:0] in_scan_code,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CharW-1:0] out_ascii_char,
  output logic [ModW-1:0]  out_modifier_flags
);

  `include "scancode_to_ascii_decoder_core_assert.svh"

  logic             s1_valid_r, s1_valid_nxt;
  logic [CodeW-1:0] s1_code_r;
  logic [ModW-1:0]  mod_r;
  logic             out_valid_r, out_valid_nxt;
  logic [CharW-1:0] out_char_r;
  logic [ModW-1:0]  out_mod_r;
  logic             out_free;
  logic             advance;
  dec_res_t         dec;

  sc2a_decode u_decode (
    .code    (s1_code_r),
    .mod_cur (mod_r),
    .res     (dec)
  );

  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && (!dec.emit || out_free);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && dec.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mod_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        mod_r <= dec.mod_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_code_r <= in_scan_code;
    end
    if (advance && dec.emit) begin
      out_char_r <= dec.ch;
      out_mod_r  <= dec.mod_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ascii_char     = out_char_r;
  assign out_modifier_flags = out_mod_r;

  `SC2A_ASSERT_IMPL(a_out_char_nonzero, out_valid_r, out_char_r != '0)
  `SC2A_ASSERT_NEXT(a_out_mod_matches, advance && dec.emit, out_mod_r == mod_r)
  `SC2A_ASSERT_NEXT(a_break_no_result, advance && s1_code_r[BreakBit],
                    out_valid_r == $past(out_valid_r && !out_ready))
  `SC2A_ASSERT_IMPL(a_stall_needs_item, !in_ready, s1_valid_r && out_valid_r)

endmodule
